// ----- src/mhpq_pkg.sv -----
`timescale 1ns / 1ps

package mhpq_pkg;

  // Heap geometry
  localparam int CAPACITY = 1024;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 32;

  // Operation selector codes
  localparam logic [1:0] KIND_INSERT   = 2'd0;
  localparam logic [1:0] KIND_EXTRACT  = 2'd1;
  localparam logic [1:0] KIND_INCREASE = 2'd2;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_FULL    = 3'd2,
    ST_SMALLER = 3'd3,
    ST_BADPOS  = 3'd4
  } status_t;

  typedef struct packed {
    logic [1:0]              kind;
    logic signed [KEY_W-1:0] key;
    logic [CNT_W-1:0]        position;
  } in_item_t;

  typedef struct packed {
    status_t                 status;
    logic signed [KEY_W-1:0] extracted;
    logic signed [KEY_W-1:0] top_key;
    logic [CNT_W-1:0]        occupancy;
  } out_item_t;

endpackage

// ----- src/max_heap_priority_queue_unit.sv -----
`timescale 1ns / 1ps
// Channel   Ports                      Handshake
// command   start, busy, in_item       taken when start && !busy
// result    out_valid, out_item        one-cycle strobe, always taken
//
// One operation at a time; busy stays high until its result is issued.
// Insert and increase-key sift up one level per S_UP_CHK (parent read) and
// S_UP_CMP (compare and write) pair; extract sifts down one level per S_DN_RD
// (both children read on the two read ports) and S_DN_CMP (compare and write)
// pair, the registered memory read lying between the two. Items rejected at
// issue (full, empty, bad position) and no-op items answer the next cycle.
// Reset is synchronous and empties the heap; memory contents are not cleared.
// No result back-pressure.

module max_heap_priority_queue_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  mhpq_pkg::in_item_t  in_item,
  output logic                out_valid,
  output mhpq_pkg::out_item_t out_item
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EX_LD,
    S_INC_RD,
    S_UP_CHK,
    S_UP_CMP,
    S_DN_RD,
    S_DN_CMP
  } state_t;

  localparam int AW = mhpq_pkg::ADDR_W;
  localparam int CW = mhpq_pkg::CNT_W;
  localparam int KW = mhpq_pkg::KEY_W;

  state_t                state_r, state_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic signed [KW-1:0]  root_r, root_nxt;
  logic signed [KW-1:0]  val_r, val_nxt;
  logic [CW-1:0]         idx_r, idx_nxt;
  logic signed [KW-1:0]  ext_r, ext_nxt;
  logic                  out_valid_r, out_valid_nxt;
  mhpq_pkg::out_item_t   out_item_r, out_item_nxt;

  logic signed [KW-1:0]  heap_mem [mhpq_pkg::CAPACITY];
  logic signed [KW-1:0]  rd0_r, rd1_r;
  logic [AW-1:0]         ra0, ra1, wa;
  logic                  we;
  logic signed [KW-1:0]  wd;

  logic                  fin;
  mhpq_pkg::status_t     fin_status;

  logic [CW-1:0]         cnt_m1, cnt_p1, idx_m1, parent, par_m1, pos_m1;
  logic [CW:0]           lchild, rchild, lchild_m1;
  logic                  take_l, take_r, r_ok;
  logic signed [KW-1:0]  best;

  // Index arithmetic around the current hole
  assign cnt_m1    = count_r - CW'(1);
  assign cnt_p1    = count_r + CW'(1);
  assign idx_m1    = idx_r - CW'(1);
  assign parent    = idx_r >> 1;
  assign par_m1    = parent - CW'(1);
  assign pos_m1    = in_item.position - CW'(1);
  assign lchild    = {idx_r, 1'b0};
  assign rchild    = {idx_r, 1'b1};
  assign lchild_m1 = lchild - (CW+1)'(1);

  // Pick the larger child, ties keep the hole's key
  assign r_ok   = rchild <= {1'b0, count_r};
  assign take_l = rd0_r > val_r;
  assign best   = take_l ? rd0_r : val_r;
  assign take_r = r_ok && (rd1_r > best);

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    root_nxt      = root_r;
    val_nxt       = val_r;
    idx_nxt       = idx_r;
    ext_nxt       = ext_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    we            = 1'b0;
    wa            = idx_m1[AW-1:0];
    wd            = val_r;
    ra0           = '0;
    ra1           = '0;
    fin           = 1'b0;
    fin_status    = mhpq_pkg::ST_OK;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          ext_nxt = '0;
          unique case (in_item.kind)
            mhpq_pkg::KIND_INSERT: begin
              if (count_r >= CW'(mhpq_pkg::CAPACITY)) begin
                fin        = 1'b1;
                fin_status = mhpq_pkg::ST_FULL;
              end else begin
                count_nxt = cnt_p1;
                val_nxt   = in_item.key;
                idx_nxt   = cnt_p1;
                state_nxt = S_UP_CHK;
              end
            end
            mhpq_pkg::KIND_EXTRACT: begin
              if (count_r == '0) begin
                fin        = 1'b1;
                fin_status = mhpq_pkg::ST_EMPTY;
              end else begin
                ext_nxt   = root_r;
                count_nxt = cnt_m1;
                ra0       = cnt_m1[AW-1:0];
                state_nxt = S_EX_LD;
              end
            end
            mhpq_pkg::KIND_INCREASE: begin
              if (in_item.position == '0 || in_item.position > count_r) begin
                fin        = 1'b1;
                fin_status = mhpq_pkg::ST_BADPOS;
              end else begin
                ra0       = pos_m1[AW-1:0];
                val_nxt   = in_item.key;
                idx_nxt   = in_item.position;
                state_nxt = S_INC_RD;
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end

      // Take the last entry as the key to sift down from the root
      S_EX_LD: begin
        val_nxt = rd0_r;
        if (count_r == '0) begin
          fin = 1'b1;
        end else begin
          idx_nxt   = CW'(1);
          state_nxt = S_DN_RD;
        end
      end

      // Reject a new key below the old one
      S_INC_RD: begin
        if (rd0_r > val_r) begin
          fin        = 1'b1;
          fin_status = mhpq_pkg::ST_SMALLER;
        end else begin
          state_nxt = S_UP_CHK;
        end
      end

      // Stop at the root, else fetch the parent
      S_UP_CHK: begin
        if (idx_r == CW'(1)) begin
          we  = 1'b1;
          fin = 1'b1;
        end else begin
          ra0       = par_m1[AW-1:0];
          state_nxt = S_UP_CMP;
        end
      end

      // Move the parent down or drop the key into the hole
      S_UP_CMP: begin
        we = 1'b1;
        if (val_r > rd0_r) begin
          wd        = rd0_r;
          idx_nxt   = parent;
          state_nxt = S_UP_CHK;
        end else begin
          fin = 1'b1;
        end
      end

      // Stop at a leaf, else fetch both children
      S_DN_RD: begin
        if (lchild > {1'b0, count_r}) begin
          we  = 1'b1;
          fin = 1'b1;
        end else begin
          ra0       = lchild_m1[AW-1:0];
          ra1       = lchild[AW-1:0];
          state_nxt = S_DN_CMP;
        end
      end

      // Move the larger child up or drop the key into the hole
      S_DN_CMP: begin
        we = 1'b1;
        if (take_r) begin
          wd        = rd1_r;
          idx_nxt   = rchild[CW-1:0];
          state_nxt = S_DN_RD;
        end else if (take_l) begin
          wd        = rd0_r;
          idx_nxt   = lchild[CW-1:0];
          state_nxt = S_DN_RD;
        end else begin
          fin = 1'b1;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Mirror writes to the root
    if (we && wa == '0) begin
      root_nxt = wd;
    end

    // Issue the result item
    if (fin) begin
      state_nxt              = S_IDLE;
      out_valid_nxt          = 1'b1;
      out_item_nxt.status    = fin_status;
      out_item_nxt.extracted = ext_nxt;
      out_item_nxt.top_key   = (count_nxt != '0) ? root_nxt : '0;
      out_item_nxt.occupancy = count_nxt;
    end
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    root_r     <= root_nxt;
    val_r      <= val_nxt;
    idx_r      <= idx_nxt;
    ext_r      <= ext_nxt;
    out_item_r <= out_item_nxt;
  end

  // Heap memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (we) begin
      heap_mem[wa] <= wd;
    end
    rd0_r <= heap_mem[ra0];
    rd1_r <= heap_mem[ra1];
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Results only appear once the sequencer is back in idle
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(mhpq_pkg::CAPACITY))
    else $error("heap count above capacity");

  a_noop_quick: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.kind != mhpq_pkg::KIND_INSERT &&
     in_item.kind != mhpq_pkg::KIND_EXTRACT &&
     in_item.kind != mhpq_pkg::KIND_INCREASE) |=> out_valid)
    else $error("no-op item not answered next cycle");

  a_err_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status != mhpq_pkg::ST_OK) |->
      (count_r == $past(count_r)))
    else $error("rejected item changed the count");

  a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.occupancy == '0) |-> (out_item.top_key == '0))
    else $error("empty heap reports a nonzero top key");

endmodule
